// ===== design/convex_polygon_overlap_test_unit_macros.svh =====
// Assertion macros for the convex polygon overlap test unit.
// Included by design files that check their own control logic; no other dependencies.
`ifndef CONVEX_POLYGON_OVERLAP_TEST_UNIT_MACROS_SVH
`define CONVEX_POLYGON_OVERLAP_TEST_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define CPOT_ASSERT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cpot: assertion failed");
`define CPOT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cpot: assertion failed");
`else
`define CPOT_ASSERT(label, clk, rstn, ante, cons)
`define CPOT_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== design/cpot_pkg.sv =====
// Shared types, codes and sizes for the convex polygon overlap test unit.
// No dependencies; used by cpot_norm, the top level and the bench.
`default_nettype none
package cpot_pkg;

    localparam int MAX_VERTS = 16;
    localparam int IDX_W     = $clog2(MAX_VERTS);
    localparam int CNT_W     = $clog2(MAX_VERTS + 1);
    localparam int COORD_W   = 24;
    localparam int EDGE_W    = COORD_W + 1;
    localparam int NRM_W     = 16;
    localparam int PROD_W    = NRM_W + COORD_W;
    localparam int PROJ_W    = PROD_W + 1;
    localparam int GAP_W     = PROJ_W + 1;
    localparam int SUM_W     = COORD_W + CNT_W;
    localparam int CEN_W     = SUM_W + CNT_W + 2;
    localparam int DEPTH_W   = 24;
    localparam int RIDX_W    = 4;
    localparam int ROOT_STEPS = 32;
    localparam int DIV_W     = 46;
    localparam int NSTEP_W   = 6;

    typedef logic [1:0] action_t;
    localparam action_t ACT_LOAD_A = 2'd0;
    localparam action_t ACT_LOAD_B = 2'd1;
    localparam action_t ACT_RUN    = 2'd2;

    typedef enum logic [1:0] {
        STATUS_OVERLAP   = 2'd0,
        STATUS_SEPARATED = 2'd1,
        STATUS_EMPTY     = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD1, ST_RD2, ST_EDGE, ST_NORM, ST_PROJ, ST_GAP,
        ST_CEN1, ST_CEN2, ST_CEN3, ST_DEEP, ST_FIN, ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        NS_IDLE, NS_SQ, NS_SUM, NS_ROOT, NS_PREP, NS_DIV, NS_DONE
    } nstate_t;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } vert_t;

    typedef struct packed {
        logic                     start;
        logic signed [EDGE_W-1:0] ex;
        logic signed [EDGE_W-1:0] ey;
    } nrm_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
    } nrm_rsp_t;

endpackage
`default_nettype wire

// ===== design/cpot_norm.sv =====
// Edge normal unit: squared length, bit-serial square root, two restoring dividers.
// Depends on cpot_pkg.
`default_nettype none
module cpot_norm (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cpot_pkg::nrm_req_t req,
    output cpot_pkg::nrm_rsp_t      rsp
);

    cpot_pkg::nstate_t state_reg, state_next;

    logic [cpot_pkg::COORD_W-1:0]   mx_reg, my_reg;
    logic                           sx_reg, sy_reg;
    logic [2*cpot_pkg::COORD_W-1:0] sq_x_reg, sq_y_reg;
    logic [63:0]                    rem_reg, res_reg, bit_reg;
    logic [31:0]                    len_reg;
    logic [cpot_pkg::DIV_W-1:0]     dx_reg, dy_reg;
    logic [32:0]                    rx_reg, ry_reg;
    logic [cpot_pkg::NSTEP_W-1:0]   step_reg;

    logic [cpot_pkg::EDGE_W-1:0]    abs_x, abs_y;
    logic [2*cpot_pkg::COORD_W:0]   sq_sum;
    logic [63:0]                    trial;
    logic [32:0]                    sh_x, sh_y;
    logic [cpot_pkg::NRM_W-1:0]     q_x, q_y;

    assign abs_x  = req.ex[cpot_pkg::EDGE_W-1] ? cpot_pkg::EDGE_W'(-req.ex) : req.ex;
    assign abs_y  = req.ey[cpot_pkg::EDGE_W-1] ? cpot_pkg::EDGE_W'(-req.ey) : req.ey;
    assign sq_sum = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
    assign trial  = res_reg + bit_reg;
    assign sh_x   = {rx_reg[31:0], dx_reg[cpot_pkg::DIV_W-1]};
    assign sh_y   = {ry_reg[31:0], dy_reg[cpot_pkg::DIV_W-1]};
    assign q_x    = dx_reg[cpot_pkg::NRM_W-1:0];
    assign q_y    = dy_reg[cpot_pkg::NRM_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cpot_pkg::NS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        rsp.done   = 1'b0;
        rsp.nx     = '0;
        rsp.ny     = '0;
        case (state_reg)
            cpot_pkg::NS_IDLE: begin
                if (req.start) state_next = cpot_pkg::NS_SQ;
            end
            cpot_pkg::NS_SQ:   state_next = cpot_pkg::NS_SUM;
            cpot_pkg::NS_SUM:  state_next = cpot_pkg::NS_ROOT;
            cpot_pkg::NS_ROOT: begin
                if (step_reg == cpot_pkg::NSTEP_W'(cpot_pkg::ROOT_STEPS - 1)) begin
                    state_next = cpot_pkg::NS_PREP;
                end
            end
            cpot_pkg::NS_PREP: state_next = cpot_pkg::NS_DIV;
            cpot_pkg::NS_DIV: begin
                if (step_reg == cpot_pkg::NSTEP_W'(cpot_pkg::DIV_W - 1)) begin
                    state_next = cpot_pkg::NS_DONE;
                end
            end
            cpot_pkg::NS_DONE: begin
                rsp.done   = 1'b1;
                // zero-length edge gives a zero normal
                if (len_reg != '0) begin
                    rsp.nx = sx_reg ? cpot_pkg::NRM_W'(-q_x) : q_x;
                    rsp.ny = sy_reg ? cpot_pkg::NRM_W'(-q_y) : q_y;
                end
                state_next = cpot_pkg::NS_IDLE;
            end
            default: state_next = cpot_pkg::NS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            cpot_pkg::NS_IDLE: begin
                mx_reg <= abs_x[cpot_pkg::COORD_W-1:0];
                my_reg <= abs_y[cpot_pkg::COORD_W-1:0];
                sx_reg <= req.ex[cpot_pkg::EDGE_W-1];
                sy_reg <= req.ey[cpot_pkg::EDGE_W-1];
            end
            cpot_pkg::NS_SQ: begin
                sq_x_reg <= mx_reg * mx_reg;
                sq_y_reg <= my_reg * my_reg;
            end
            cpot_pkg::NS_SUM: begin
                rem_reg  <= 64'({sq_sum, 14'd0});
                res_reg  <= '0;
                bit_reg  <= 64'(1) << 62;
                step_reg <= '0;
            end
            cpot_pkg::NS_ROOT: begin
                if (rem_reg >= trial) begin
                    rem_reg <= rem_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg  <= bit_reg >> 2;
                step_reg <= step_reg + 1'b1;
            end
            cpot_pkg::NS_PREP: begin
                len_reg  <= res_reg[31:0];
                dx_reg   <= cpot_pkg::DIV_W'({mx_reg, 21'd0}) + cpot_pkg::DIV_W'(res_reg[31:1]);
                dy_reg   <= cpot_pkg::DIV_W'({my_reg, 21'd0}) + cpot_pkg::DIV_W'(res_reg[31:1]);
                rx_reg   <= '0;
                ry_reg   <= '0;
                step_reg <= '0;
            end
            cpot_pkg::NS_DIV: begin
                // shift in one dividend bit, quotient bits fill from the bottom
                if (sh_x >= {1'b0, len_reg}) begin
                    rx_reg <= sh_x - {1'b0, len_reg};
                    dx_reg <= {dx_reg[cpot_pkg::DIV_W-2:0], 1'b1};
                end else begin
                    rx_reg <= sh_x;
                    dx_reg <= {dx_reg[cpot_pkg::DIV_W-2:0], 1'b0};
                end
                if (sh_y >= {1'b0, len_reg}) begin
                    ry_reg <= sh_y - {1'b0, len_reg};
                    dy_reg <= {dy_reg[cpot_pkg::DIV_W-2:0], 1'b1};
                end else begin
                    ry_reg <= sh_y;
                    dy_reg <= {dy_reg[cpot_pkg::DIV_W-2:0], 1'b0};
                end
                step_reg <= step_reg + 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== design/convex_polygon_overlap_test_unit.sv =====
// A vertex beat is taken in every cycle while the unit is idle. A run beat blocks the input
// until its result is loaded into the output register; each axis takes the normal unit's
// 32-step root and 46-step divide plus one vertex-memory read per vertex. Result goes out
// through an output register; vertex beats are taken while it waits. Reset (aresetn,
// synchronous, active low) empties both polygons and drops any result. Depends on
// cpot_pkg, cpot_norm and the macros header.
`default_nettype none
`include "convex_polygon_overlap_test_unit_macros.svh"
module convex_polygon_overlap_test_unit (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [1:0]                           s_action,
    input  wire logic signed [cpot_pkg::COORD_W-1:0]  s_pos_x,
    input  wire logic signed [cpot_pkg::COORD_W-1:0]  s_pos_y,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [1:0]                                m_status,
    output logic signed [cpot_pkg::NRM_W-1:0]         m_normal_x,
    output logic signed [cpot_pkg::NRM_W-1:0]         m_normal_y,
    output logic [cpot_pkg::DEPTH_W-1:0]              m_depth,
    output logic                                      m_edge_on_a,
    output logic [cpot_pkg::RIDX_W-1:0]               m_edge_first,
    output logic [cpot_pkg::RIDX_W-1:0]               m_edge_second,
    output logic [cpot_pkg::RIDX_W-1:0]               m_deep_vertex
);

    localparam int IW = cpot_pkg::IDX_W;
    localparam int CW = cpot_pkg::CNT_W;
    localparam int PW = cpot_pkg::PROJ_W;
    localparam int GW = cpot_pkg::GAP_W;
    localparam int EW = cpot_pkg::CEN_W;
    localparam int NW = cpot_pkg::NRM_W;

    cpot_pkg::state_t  state_reg, state_next;
    cpot_pkg::vert_t   mem_a [cpot_pkg::MAX_VERTS];
    cpot_pkg::vert_t   mem_b [cpot_pkg::MAX_VERTS];
    cpot_pkg::vert_t   rd_a_reg, rd_b_reg, p1_reg;
    cpot_pkg::nrm_req_t nrm_req;
    cpot_pkg::nrm_rsp_t nrm_rsp;
    cpot_pkg::status_t res_status_reg;

    logic [CW-1:0] cnt_a_reg, cnt_b_reg, ax_reg, idx_reg;
    logic          pass_reg, have_reg, on_a_reg;
    logic signed [cpot_pkg::SUM_W-1:0] sum_ax_reg, sum_ay_reg, sum_bx_reg, sum_by_reg;
    logic signed [NW-1:0] cur_nx_reg, cur_ny_reg, best_nx_reg, best_ny_reg;
    logic          rd_v_reg, mul_v_reg;
    logic [IW-1:0] rd_idx_reg, mul_idx_reg, e1_reg, e2_reg, deep_reg;
    logic signed [cpot_pkg::PROD_W-1:0] pax_reg, pay_reg, pbx_reg, pby_reg;
    logic signed [PW-1:0] amin_reg, amax_reg, bmin_reg, bmax_reg, dext_reg;
    logic [GW-1:0] best_reg;
    logic signed [EW-1:0] cx_reg, cy_reg;
    logic signed [EW+NW-1:0] cpx_reg, cpy_reg;
    logic [cpot_pkg::DEPTH_W-1:0] res_depth_reg;

    logic          m_valid_reg;
    logic [1:0]    m_status_reg;
    logic signed [NW-1:0] m_nx_reg, m_ny_reg;
    logic [cpot_pkg::DEPTH_W-1:0] m_depth_reg;
    logic          m_on_a_reg;
    logic [cpot_pkg::RIDX_W-1:0] m_e1_reg, m_e2_reg, m_deep_reg;

    logic          accept, load_a, load_b, run_go, run_empty, out_load;
    logic [CW-1:0] own_n, proj_lim, nlim;
    logic          last_edge, issue, sep, better;
    logic [IW-1:0] f1, f2, raddr;
    cpot_pkg::vert_t own_rd;
    logic signed [PW-1:0] da, db, dsel;
    logic          mva, mvb, mfirst;
    logic signed [GW-1:0] gap;
    logic [GW-1:0] gmag;
    logic signed [NW-1:0] use_nx, use_ny;
    logic signed [EW+NW:0] csum;
    logic [GW:0]   dround;

    assign accept    = s_valid && s_ready;
    assign load_a    = accept && s_action == cpot_pkg::ACT_LOAD_A
                       && cnt_a_reg < CW'(cpot_pkg::MAX_VERTS);
    assign load_b    = accept && s_action == cpot_pkg::ACT_LOAD_B
                       && cnt_b_reg < CW'(cpot_pkg::MAX_VERTS);
    assign run_go    = accept && s_action == cpot_pkg::ACT_RUN;
    assign run_empty = cnt_a_reg == '0 || cnt_b_reg == '0;
    assign out_load  = state_reg == cpot_pkg::ST_OUT && (!m_valid_reg || m_ready);

    // edge endpoints; B's closing edge runs from vertex 0 to the last one
    assign own_n     = pass_reg ? cnt_b_reg : cnt_a_reg;
    assign last_edge = ax_reg == own_n - 1'b1;
    always_comb begin
        if (last_edge) begin
            f1 = pass_reg ? '0 : ax_reg[IW-1:0];
            f2 = pass_reg ? ax_reg[IW-1:0] : '0;
        end else begin
            f1 = ax_reg[IW-1:0];
            f2 = IW'(ax_reg + 1'b1);
        end
        case (state_reg)
            cpot_pkg::ST_RD1: raddr = f1;
            cpot_pkg::ST_RD2: raddr = f2;
            default:          raddr = idx_reg[IW-1:0];
        endcase
    end

    assign own_rd     = pass_reg ? rd_b_reg : rd_a_reg;
    assign nrm_req.start = state_reg == cpot_pkg::ST_EDGE;
    assign nrm_req.ex = cpot_pkg::EDGE_W'(p1_reg.y) - cpot_pkg::EDGE_W'(own_rd.y);
    assign nrm_req.ey = cpot_pkg::EDGE_W'(own_rd.x) - cpot_pkg::EDGE_W'(p1_reg.x);

    cpot_norm u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (nrm_req),
        .rsp     (nrm_rsp)
    );

    // projection pipeline: read, multiply, sum and compare
    assign proj_lim = (cnt_a_reg > cnt_b_reg) ? cnt_a_reg : cnt_b_reg;
    assign nlim     = (state_reg == cpot_pkg::ST_DEEP) ? (on_a_reg ? cnt_b_reg : cnt_a_reg)
                                                        : proj_lim;
    assign issue    = (state_reg == cpot_pkg::ST_PROJ || state_reg == cpot_pkg::ST_DEEP)
                      && idx_reg < nlim;
    assign use_nx   = (state_reg == cpot_pkg::ST_DEEP) ? best_nx_reg : cur_nx_reg;
    assign use_ny   = (state_reg == cpot_pkg::ST_DEEP) ? best_ny_reg : cur_ny_reg;
    assign da       = PW'(pax_reg) + PW'(pay_reg);
    assign db       = PW'(pbx_reg) + PW'(pby_reg);
    assign dsel     = on_a_reg ? db : da;
    assign mva      = CW'(mul_idx_reg) < cnt_a_reg;
    assign mvb      = CW'(mul_idx_reg) < cnt_b_reg;
    assign mfirst   = mul_idx_reg == '0;

    assign gap    = (amin_reg < bmin_reg) ? GW'(bmin_reg) - GW'(amax_reg)
                                          : GW'(amin_reg) - GW'(bmax_reg);
    assign sep    = gap > 0;
    assign gmag   = GW'(-gap);
    assign better = !have_reg || gmag < best_reg;
    assign csum   = (EW+NW+1)'(cpx_reg) + (EW+NW+1)'(cpy_reg);
    assign dround = {1'b0, best_reg} + (GW+1)'(8192);

    always_comb begin
        state_next = state_reg;
        s_ready    = state_reg == cpot_pkg::ST_IDLE;
        case (state_reg)
            cpot_pkg::ST_IDLE: begin
                if (run_go) begin
                    state_next = run_empty ? cpot_pkg::ST_OUT : cpot_pkg::ST_RD1;
                end
            end
            cpot_pkg::ST_RD1:  state_next = cpot_pkg::ST_RD2;
            cpot_pkg::ST_RD2:  state_next = cpot_pkg::ST_EDGE;
            cpot_pkg::ST_EDGE: state_next = cpot_pkg::ST_NORM;
            cpot_pkg::ST_NORM: begin
                if (nrm_rsp.done) state_next = cpot_pkg::ST_PROJ;
            end
            cpot_pkg::ST_PROJ: begin
                if (!issue && !rd_v_reg && !mul_v_reg) state_next = cpot_pkg::ST_GAP;
            end
            cpot_pkg::ST_GAP: begin
                if (sep) begin
                    state_next = cpot_pkg::ST_OUT;
                end else if (last_edge && pass_reg) begin
                    state_next = cpot_pkg::ST_CEN1;
                end else begin
                    state_next = cpot_pkg::ST_RD1;
                end
            end
            cpot_pkg::ST_CEN1: state_next = cpot_pkg::ST_CEN2;
            cpot_pkg::ST_CEN2: state_next = cpot_pkg::ST_CEN3;
            cpot_pkg::ST_CEN3: state_next = cpot_pkg::ST_DEEP;
            cpot_pkg::ST_DEEP: begin
                if (!issue && !rd_v_reg && !mul_v_reg) state_next = cpot_pkg::ST_FIN;
            end
            cpot_pkg::ST_FIN:  state_next = cpot_pkg::ST_OUT;
            cpot_pkg::ST_OUT: begin
                if (out_load) state_next = cpot_pkg::ST_IDLE;
            end
            default: state_next = cpot_pkg::ST_IDLE;
        endcase
    end

    // vertex memories, one write and one registered read port each
    always_ff @(posedge aclk) begin
        if (load_a) mem_a[cnt_a_reg[IW-1:0]] <= '{x: s_pos_x, y: s_pos_y};
        if (load_b) mem_b[cnt_b_reg[IW-1:0]] <= '{x: s_pos_x, y: s_pos_y};
        rd_a_reg <= mem_a[raddr];
        rd_b_reg <= mem_b[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cpot_pkg::ST_IDLE;
            cnt_a_reg   <= '0;
            cnt_b_reg   <= '0;
            sum_ax_reg  <= '0;
            sum_ay_reg  <= '0;
            sum_bx_reg  <= '0;
            sum_by_reg  <= '0;
            rd_v_reg    <= 1'b0;
            mul_v_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            rd_v_reg  <= issue;
            mul_v_reg <= rd_v_reg;
            if (out_load) begin
                cnt_a_reg  <= '0;
                cnt_b_reg  <= '0;
                sum_ax_reg <= '0;
                sum_ay_reg <= '0;
                sum_bx_reg <= '0;
                sum_by_reg <= '0;
            end else begin
                if (load_a) begin
                    cnt_a_reg  <= cnt_a_reg + 1'b1;
                    sum_ax_reg <= sum_ax_reg + cpot_pkg::SUM_W'(s_pos_x);
                    sum_ay_reg <= sum_ay_reg + cpot_pkg::SUM_W'(s_pos_y);
                end
                if (load_b) begin
                    cnt_b_reg  <= cnt_b_reg + 1'b1;
                    sum_bx_reg <= sum_bx_reg + cpot_pkg::SUM_W'(s_pos_x);
                    sum_by_reg <= sum_by_reg + cpot_pkg::SUM_W'(s_pos_y);
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg  <= raddr;
        mul_idx_reg <= rd_idx_reg;
        pax_reg     <= use_nx * rd_a_reg.x;
        pay_reg     <= use_ny * rd_a_reg.y;
        pbx_reg     <= use_nx * rd_b_reg.x;
        pby_reg     <= use_ny * rd_b_reg.y;
        if (issue) idx_reg <= idx_reg + 1'b1;

        case (state_reg)
            cpot_pkg::ST_IDLE: begin
                pass_reg       <= 1'b0;
                ax_reg         <= '0;
                have_reg       <= 1'b0;
                res_status_reg <= cpot_pkg::STATUS_EMPTY;
            end
            cpot_pkg::ST_RD2: begin
                p1_reg <= own_rd;
            end
            cpot_pkg::ST_NORM: begin
                cur_nx_reg <= nrm_rsp.nx;
                cur_ny_reg <= nrm_rsp.ny;
                idx_reg    <= '0;
            end
            cpot_pkg::ST_PROJ: begin
                if (mul_v_reg && mva) begin
                    if (mfirst || da < amin_reg) amin_reg <= da;
                    if (mfirst || da > amax_reg) amax_reg <= da;
                end
                if (mul_v_reg && mvb) begin
                    if (mfirst || db < bmin_reg) bmin_reg <= db;
                    if (mfirst || db > bmax_reg) bmax_reg <= db;
                end
            end
            cpot_pkg::ST_GAP: begin
                if (sep) begin
                    res_status_reg <= cpot_pkg::STATUS_SEPARATED;
                end else begin
                    if (better) begin
                        have_reg    <= 1'b1;
                        best_reg    <= gmag;
                        best_nx_reg <= cur_nx_reg;
                        best_ny_reg <= cur_ny_reg;
                        e1_reg      <= f1;
                        e2_reg      <= f2;
                        on_a_reg    <= !pass_reg;
                    end
                    if (last_edge) begin
                        pass_reg <= 1'b1;
                        ax_reg   <= '0;
                    end else begin
                        ax_reg <= ax_reg + 1'b1;
                    end
                end
            end
            cpot_pkg::ST_CEN1: begin
                cx_reg <= EW'(sum_ax_reg) * EW'($signed({1'b0, cnt_b_reg}))
                        - EW'(sum_bx_reg) * EW'($signed({1'b0, cnt_a_reg}));
                cy_reg <= EW'(sum_ay_reg) * EW'($signed({1'b0, cnt_b_reg}))
                        - EW'(sum_by_reg) * EW'($signed({1'b0, cnt_a_reg}));
            end
            cpot_pkg::ST_CEN2: begin
                cpx_reg <= best_nx_reg * cx_reg;
                cpy_reg <= best_ny_reg * cy_reg;
            end
            cpot_pkg::ST_CEN3: begin
                // flip so the normal points from B's centre toward A's
                if (csum < 0) begin
                    best_nx_reg <= NW'(-best_nx_reg);
                    best_ny_reg <= NW'(-best_ny_reg);
                end
                idx_reg <= '0;
            end
            cpot_pkg::ST_DEEP: begin
                if (mul_v_reg && (mfirst || (on_a_reg ? dsel > dext_reg : dsel < dext_reg))) begin
                    dext_reg <= dsel;
                    deep_reg <= mul_idx_reg;
                end
            end
            cpot_pkg::ST_FIN: begin
                res_status_reg <= cpot_pkg::STATUS_OVERLAP;
                res_depth_reg  <= (dround[GW:14] > (GW-13)'(24'hFFFFFF))
                                  ? 24'hFFFFFF : dround[14 +: cpot_pkg::DEPTH_W];
            end
            default: begin
            end
        endcase

        if (out_load) begin
            m_status_reg <= res_status_reg;
            if (res_status_reg == cpot_pkg::STATUS_OVERLAP) begin
                m_nx_reg    <= best_nx_reg;
                m_ny_reg    <= best_ny_reg;
                m_depth_reg <= res_depth_reg;
                m_on_a_reg  <= on_a_reg;
                m_e1_reg    <= cpot_pkg::RIDX_W'(e1_reg);
                m_e2_reg    <= cpot_pkg::RIDX_W'(e2_reg);
                m_deep_reg  <= cpot_pkg::RIDX_W'(deep_reg);
            end else begin
                m_nx_reg    <= '0;
                m_ny_reg    <= '0;
                m_depth_reg <= '0;
                m_on_a_reg  <= 1'b0;
                m_e1_reg    <= '0;
                m_e2_reg    <= '0;
                m_deep_reg  <= '0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_normal_x    = m_nx_reg;
    assign m_normal_y    = m_ny_reg;
    assign m_depth       = m_depth_reg;
    assign m_edge_on_a   = m_on_a_reg;
    assign m_edge_first  = m_e1_reg;
    assign m_edge_second = m_e2_reg;
    assign m_deep_vertex = m_deep_reg;

    `CPOT_ASSERT_NEXT(a_empty_run, aclk, aresetn, (run_go && run_empty), (state_reg == cpot_pkg::ST_OUT && res_status_reg == cpot_pkg::STATUS_EMPTY))
    `CPOT_ASSERT(a_norm_done_waited, aclk, aresetn, nrm_rsp.done, state_reg == cpot_pkg::ST_NORM)
    `CPOT_ASSERT(a_counts_cleared, aclk, aresetn, $rose(m_valid_reg), (cnt_a_reg == '0 && cnt_b_reg == '0))
    `CPOT_ASSERT(a_gap_after_drain, aclk, aresetn, state_reg == cpot_pkg::ST_GAP, (!rd_v_reg && !mul_v_reg))

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for convex_polygon_overlap_test_unit: random convex polygon pairs,
// directed corner cases and noise, checked against a built-in overlap predictor.
// Depends on cpot_pkg and the unit's RTL.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam cpot_pkg::action_t ACT_NONE = 2'd3;
    localparam longint  COORD_MAX = 8388607;
    localparam longint  COORD_MIN = -8388608;

    typedef struct packed {
        logic [1:0]        status;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic [23:0]       depth;
        logic              on_a;
        logic [3:0]        e1;
        logic [3:0]        e2;
        logic [3:0]        deep;
    } overlap_res_t;

    class overlap_scoreboard;
        overlap_res_t pending_q[$];
        longint ax[cpot_pkg::MAX_VERTS], ay[cpot_pkg::MAX_VERTS];
        longint bxv[cpot_pkg::MAX_VERTS], byv[cpot_pkg::MAX_VERTS];
        int na, nb;
        int errors, checked, n_sep, n_ovl, n_empty;

        task report(string what, longint got, longint want);
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
            errors++;
        endtask

        function longint unsigned root64(longint unsigned v);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        function longint scale_q14(longint e, longint unsigned len);
            longint unsigned mag, q;
            mag = longint'(e < 0 ? -e : e) << 21;
            q = (mag + len / 2) / len;
            return e < 0 ? -longint'(q) : longint'(q);
        endfunction

        function void edge_unit(longint px, longint py, longint qx, longint qy,
                                output longint nx, output longint ny);
            longint ex, ey;
            longint unsigned s, len;
            ex = py - qy;
            ey = qx - px;
            s = longint'(ex * ex) + longint'(ey * ey);
            len = root64(s << 14);
            if (len == 0) begin
                nx = 0;
                ny = 0;
            end else begin
                nx = scale_q14(ex, len);
                ny = scale_q14(ey, len);
            end
        endfunction

        function void span(bit of_b, longint nx, longint ny, output longint lo, output longint hi);
            longint d;
            int n;
            n = of_b ? nb : na;
            lo = of_b ? nx * bxv[0] + ny * byv[0] : nx * ax[0] + ny * ay[0];
            hi = lo;
            for (int i = 1; i < n; i++) begin
                d = of_b ? nx * bxv[i] + ny * byv[i] : nx * ax[i] + ny * ay[i];
                if (d < lo) lo = d;
                else if (d > hi) hi = d;
            end
        endfunction

        function overlap_res_t overlap_result();
            overlap_res_t r;
            longint best, bnx, bny, nx, ny, alo, ahi, blo, bhi, gap, cx, cy, d, mind, dep;
            longint sax, say, sbx, sby;
            int e1, e2, f1, f2, n, deep;
            bit on_a, have;
            r = '0;
            if (na == 0 || nb == 0) begin
                r.status = cpot_pkg::STATUS_EMPTY;
                return r;
            end
            have = 0; best = 0; bnx = 0; bny = 0; e1 = 0; e2 = 0; on_a = 1;
            for (int pass = 0; pass < 2; pass++) begin
                n = pass == 0 ? na : nb;
                for (int i = 0; i < n; i++) begin
                    if (i == n - 1) begin
                        f1 = pass == 0 ? i : 0;
                        f2 = pass == 0 ? 0 : i;
                    end else begin
                        f1 = i;
                        f2 = i + 1;
                    end
                    if (pass == 0) edge_unit(ax[f1], ay[f1], ax[f2], ay[f2], nx, ny);
                    else           edge_unit(bxv[f1], byv[f1], bxv[f2], byv[f2], nx, ny);
                    span(0, nx, ny, alo, ahi);
                    span(1, nx, ny, blo, bhi);
                    gap = alo < blo ? blo - ahi : alo - bhi;
                    if (gap > 0) begin
                        r.status = cpot_pkg::STATUS_SEPARATED;
                        return r;
                    end
                    gap = -gap;
                    if (!have || gap < best) begin
                        have = 1; best = gap; bnx = nx; bny = ny;
                        e1 = f1; e2 = f2; on_a = pass == 0;
                    end
                end
            end
            sax = 0; say = 0; sbx = 0; sby = 0;
            for (int i = 0; i < na; i++) begin sax += ax[i]; say += ay[i]; end
            for (int i = 0; i < nb; i++) begin sbx += bxv[i]; sby += byv[i]; end
            cx = sax * nb - sbx * na;
            cy = say * nb - sby * na;
            // flip so the normal points from B's centre toward A's
            if (bnx * cx + bny * cy < 0) begin
                bnx = -bnx;
                bny = -bny;
            end
            n = on_a ? nb : na;
            mind = 0; deep = 0;
            for (int i = 0; i < n; i++) begin
                d = on_a ? -(bnx * bxv[i] + bny * byv[i]) : bnx * ax[i] + bny * ay[i];
                if (i == 0 || d < mind) begin
                    mind = d;
                    deep = i;
                end
            end
            dep = (best + 8192) >>> 14;
            if (dep > 64'hFFFFFF) dep = 64'hFFFFFF;
            r.status = cpot_pkg::STATUS_OVERLAP;
            r.nx = bnx[15:0];
            r.ny = bny[15:0];
            r.depth = dep[23:0];
            r.on_a = on_a;
            r.e1 = e1[3:0];
            r.e2 = e2[3:0];
            r.deep = deep[3:0];
            return r;
        endfunction

        function void note_beat(cpot_pkg::action_t act, longint x, longint y);
            overlap_res_t r;
            case (act)
                cpot_pkg::ACT_LOAD_A: begin
                    if (na < cpot_pkg::MAX_VERTS) begin ax[na] = x; ay[na] = y; na++; end
                end
                cpot_pkg::ACT_LOAD_B: begin
                    if (nb < cpot_pkg::MAX_VERTS) begin bxv[nb] = x; byv[nb] = y; nb++; end
                end
                cpot_pkg::ACT_RUN: begin
                    r = overlap_result();
                    case (r.status)
                        cpot_pkg::STATUS_OVERLAP:   n_ovl++;
                        cpot_pkg::STATUS_SEPARATED: n_sep++;
                        default:                    n_empty++;
                    endcase
                    pending_q = {pending_q, r};
                    na = 0;
                    nb = 0;
                end
                default: ;
            endcase
        endfunction

        task check_result(overlap_res_t got);
            overlap_res_t want;
            checked++;
            if (pending_q.size() == 0) begin
                $display("mismatch at %0t: result beat with nothing pending", $time);
                errors++;
            end else begin
                want = pending_q[0];
                pending_q.delete(0);
                if (got.status != want.status) report("status", got.status, want.status);
                if (got.nx != want.nx)       report("normal_x", got.nx, want.nx);
                if (got.ny != want.ny)       report("normal_y", got.ny, want.ny);
                if (got.depth != want.depth) report("depth", got.depth, want.depth);
                if (got.on_a != want.on_a)   report("edge_on_a", got.on_a, want.on_a);
                if (got.e1 != want.e1)       report("edge_first", got.e1, want.e1);
                if (got.e2 != want.e2)       report("edge_second", got.e2, want.e2);
                if (got.deep != want.deep)   report("deep_vertex", got.deep, want.deep);
            end
        endtask
    endclass

    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready;
    logic [1:0] s_action;
    logic signed [cpot_pkg::COORD_W-1:0] s_pos_x, s_pos_y;
    logic [1:0] m_status;
    logic signed [cpot_pkg::NRM_W-1:0] m_normal_x, m_normal_y;
    logic [cpot_pkg::DEPTH_W-1:0] m_depth;
    logic m_edge_on_a;
    logic [cpot_pkg::RIDX_W-1:0] m_edge_first, m_edge_second, m_deep_vertex;

    overlap_scoreboard sb = new();
    int beats_sent;
    bit sender_busy_mode, sink_busy_mode;

    convex_polygon_overlap_test_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_normal_x(m_normal_x), .m_normal_y(m_normal_y), .m_depth(m_depth),
        .m_edge_on_a(m_edge_on_a), .m_edge_first(m_edge_first),
        .m_edge_second(m_edge_second), .m_deep_vertex(m_deep_vertex)
    );

    always begin
        aclk = 1'b0; #6;
        aclk = 1'b1; #6;
    end

    function automatic int gap_len(bit busy);
        if (!busy || $urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // outputs are sampled at the falling edge; inputs only move at the rising edge
    task automatic send_beat(cpot_pkg::action_t act, longint x, longint y);
        int g;
        g = gap_len(sender_busy_mode);
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_action <= act;
        s_pos_x  <= x[23:0];
        s_pos_y  <= y[23:0];
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        sb.note_beat(act, x, y);
        beats_sent++;
    endtask

    function automatic longint clamp(longint v);
        return v > COORD_MAX ? COORD_MAX : (v < COORD_MIN ? COORD_MIN : v);
    endfunction

    task automatic send_poly(cpot_pkg::action_t act, longint cx, longint cy, longint rad, int k);
        real step, base, ang;
        step = 6.283185307 / k;
        base = $urandom_range(0, 6283) / 1000.0;
        if ($urandom_range(0, 1)) step = -step;
        for (int i = 0; i < k; i++) begin
            ang = base + step * i + step * ($urandom_range(0, 400) / 1000.0);
            send_beat(act, clamp(cx + longint'($rtoi(rad * $cos(ang)))),
                      clamp(cy + longint'($rtoi(rad * $sin(ang)))));
        end
    endtask

    // hold the sender idle and wait until every result is back
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending_q.size() != 0);
    endtask

    function automatic longint rnd_coord();
        return longint'($signed($urandom_range(0, 24'hFFFFFF) << 8)) >>> 8;
    endfunction

    // sink stalls: mostly short, a few long, with stall-free stretches
    int sink_hold;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_hold <= 0;
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            sink_hold <= gap_len(sink_busy_mode);
        end
    end

    always @(negedge aclk) begin
        overlap_res_t got;
        if (aresetn && m_valid && m_ready) begin
            got = {m_status, m_normal_x, m_normal_y, m_depth, m_edge_on_a,
                   m_edge_first, m_edge_second, m_deep_vertex};
            sb.check_result(got);
        end
    end

    initial begin
        #100_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        longint cx, cy, rad;
        int k, kb, runs_random;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_action <= cpot_pkg::ACT_LOAD_A;
        s_pos_x <= '0;
        s_pos_y <= '0;
        sender_busy_mode = 0;
        sink_busy_mode = 0;
        beats_sent = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // both empty, A empty, B empty
        send_beat(cpot_pkg::ACT_RUN, 0, 0);
        send_beat(cpot_pkg::ACT_LOAD_B, 256, 256);
        send_beat(cpot_pkg::ACT_RUN, COORD_MAX, COORD_MIN);
        send_beat(cpot_pkg::ACT_LOAD_A, -256, 256);
        send_beat(cpot_pkg::ACT_RUN, 0, 0);
        // ignored action
        send_beat(ACT_NONE, COORD_MAX, COORD_MAX);
        // extreme corners on both: triangles that meet only along their shared diagonal
        send_beat(cpot_pkg::ACT_LOAD_A, COORD_MIN, COORD_MIN);
        send_beat(cpot_pkg::ACT_LOAD_A, COORD_MAX, COORD_MIN);
        send_beat(cpot_pkg::ACT_LOAD_A, COORD_MAX, COORD_MAX);
        send_beat(cpot_pkg::ACT_LOAD_B, COORD_MAX, COORD_MAX);
        send_beat(cpot_pkg::ACT_LOAD_B, COORD_MIN, COORD_MAX);
        send_beat(cpot_pkg::ACT_LOAD_B, COORD_MIN, COORD_MIN);
        send_beat(cpot_pkg::ACT_RUN, 0, 0);
        // single points: zero-length edges, equal points give ties
        send_beat(cpot_pkg::ACT_LOAD_A, 100, -100);
        send_beat(cpot_pkg::ACT_LOAD_B, 100, -100);
        send_beat(cpot_pkg::ACT_RUN, 0, 0);
        // identical squares with a repeated vertex
        for (int p = 0; p < 2; p++) begin
            send_beat(p ? cpot_pkg::ACT_LOAD_B : cpot_pkg::ACT_LOAD_A, 0, 0);
            send_beat(p ? cpot_pkg::ACT_LOAD_B : cpot_pkg::ACT_LOAD_A, 0, 0);
            send_beat(p ? cpot_pkg::ACT_LOAD_B : cpot_pkg::ACT_LOAD_A, 2560, 0);
            send_beat(p ? cpot_pkg::ACT_LOAD_B : cpot_pkg::ACT_LOAD_A, 2560, 2560);
            send_beat(p ? cpot_pkg::ACT_LOAD_B : cpot_pkg::ACT_LOAD_A, 0, 2560);
        end
        send_beat(cpot_pkg::ACT_RUN, 0, 0);
        // far apart: separated
        send_poly(cpot_pkg::ACT_LOAD_A, -1000000, 0, 20000, 3);
        send_poly(cpot_pkg::ACT_LOAD_B, 1000000, 0, 20000, 4);
        send_beat(cpot_pkg::ACT_RUN, 0, 0);
        // overfill both stores
        send_poly(cpot_pkg::ACT_LOAD_A, 0, 0, 500000, 18);
        send_poly(cpot_pkg::ACT_LOAD_B, 300000, 100000, 400000, 17);
        send_beat(cpot_pkg::ACT_RUN, 0, 0);
        drain_results();

        runs_random = 0;
        while (beats_sent < 620 || runs_random < 40) begin
            if ($urandom_range(0, 3) == 0) sender_busy_mode = !sender_busy_mode;
            if ($urandom_range(0, 3) == 0) sink_busy_mode = !sink_busy_mode;
            case ($urandom_range(0, 9))
                0: begin
                    // noise: raw full-range beats of any action
                    repeat ($urandom_range(1, 6))
                        send_beat(cpot_pkg::action_t'($urandom_range(0, 3)),
                                  rnd_coord(), rnd_coord());
                end
                default: begin
                    rad = $urandom_range(0, 3) == 0 ? $urandom_range(1, 2000000)
                                                    : $urandom_range(64, 60000);
                    cx = longint'($urandom_range(0, 8000000)) - 4000000;
                    cy = longint'($urandom_range(0, 8000000)) - 4000000;
                    k  = $urandom_range(0, 15) == 0 ? 16 : $urandom_range(1, 6);
                    kb = $urandom_range(0, 15) == 0 ? 16 : $urandom_range(1, 6);
                    send_poly(cpot_pkg::ACT_LOAD_A, cx, cy, rad, k);
                    if ($urandom_range(0, 7) == 0) send_beat(ACT_NONE, rnd_coord(), rnd_coord());
                    cx += longint'($urandom_range(0, 4 * rad)) - 2 * rad;
                    cy += longint'($urandom_range(0, 4 * rad)) - 2 * rad;
                    send_poly(cpot_pkg::ACT_LOAD_B, cx, cy, $urandom_range(rad / 2, 2 * rad), kb);
                    send_beat(cpot_pkg::ACT_RUN, rnd_coord(), rnd_coord());
                end
            endcase
            runs_random++;
            if (runs_random == 20) drain_results();
        end
        drain_results();
        repeat (50) @(posedge aclk);

        $display("beats %0d, results %0d: overlap %0d, separated %0d, empty %0d",
                 beats_sent, sb.checked, sb.n_ovl, sb.n_sep, sb.n_empty);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+design
design/cpot_pkg.sv
design/cpot_norm.sv
design/convex_polygon_overlap_test_unit.sv
bench/tb.sv
